### src/tspes_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and field layouts for the transport stream PES packetizer.
package tspes_pkg;

  // Stream and packet geometry.
  localparam int MAX_SOURCES      = 8;
  localparam int SRC_W            = 3;
  localparam int PACKET_BYTES     = 188;
  localparam int PACKET_WORDS     = PACKET_BYTES / 4;
  localparam logic [5:0] LAST_WORD_IDX = 6'(PACKET_WORDS - 1);

  // Byte and word positions inside a packet.
  localparam logic [7:0] TS_HDR_BYTES      = 8'd4;
  localparam logic [7:0] FIRST_PAYLOAD_POS = 8'd19;
  localparam logic [5:0] FIRST_DATA_WORD   = 6'd4;
  localparam logic [5:0] FIRST_PAD_WORDS   = LAST_WORD_IDX - FIRST_DATA_WORD;

  // Header field values.
  localparam logic [7:0]  SYNC_BYTE     = 8'h47;
  localparam logic [7:0]  PUSI_FLAG     = 8'h40;
  localparam logic [12:0] PID_BASE      = 13'h1e1;
  localparam logic [3:0]  PAYLOAD_ONLY  = 4'h1;
  localparam logic [7:0]  SID_AUDIO     = 8'hc0;
  localparam logic [7:0]  SID_VIDEO     = 8'he0;
  localparam logic [24:0] PES_LEN_EXTRA = 25'd8;
  localparam logic [7:0]  PES_FLAGS0    = 8'h84;
  localparam logic [7:0]  PES_FLAGS1    = 8'h80;
  localparam logic [7:0]  PES_HDR_LEN   = 8'h05;
  localparam logic [23:0] PES_START     = 24'h000001;
  localparam logic [7:0]  PTS_PREFIX    = 8'h21;

  // PTS divider: time in microseconds times 9, over 100.
  localparam logic [7:0] PTS_DIVISOR = 8'd100;
  localparam int DIV_STAGES = 7;
  localparam int PIPE_REGS  = DIV_STAGES + 1;
  localparam int INFLIGHT_W = 4;

  // Command queue between the front and back ends.
  localparam int QUEUE_DEPTH = 16;
  localparam int QPTR_W      = 4;
  localparam int QUEUE_CAP   = QUEUE_DEPTH + 1;
  localparam int OCC_W       = 5;

  // Which transport header a command opens with.
  typedef enum logic [1:0] {
    HDR_NONE,
    HDR_SHORT,
    HDR_FIRST
  } hdr_kind_t;

  // One accepted input item.
  typedef struct packed {
    logic [2:0]  source;
    logic [7:0]  data_byte;
    logic        unit_start;
    logic [23:0] unit_size;
    logic [47:0] time_us;
  } item_t;

  // One output word.
  typedef struct packed {
    logic [31:0] word;
    logic        packet_end;
    logic        run_last;
  } result_t;

  // Work for the back end: header words, at most one data word, then zero pad words.
  typedef struct packed {
    hdr_kind_t   hdr;
    logic [2:0]  src;
    logic [3:0]  cc;
    logic [7:0]  sid;
    logic [15:0] pes_len;
    logic [31:0] pts;
    logic        has_word;
    logic        use_tail;
    logic [31:0] data_word;
    logic [5:0]  zeros;
    logic        ends_packet;
  } cmd_t;

endpackage

### src/tspes_front.sv
`timescale 1ns / 1ps
// Front end: accepts payload bytes, tracks packet position and builds commands.
module tspes_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  tspes_pkg::item_t    item,
  input  logic                cfg_write,
  input  logic [7:0]          cfg_data,
  output logic                cmd_valid,
  output tspes_pkg::cmd_t     cmd,
  output logic [47:0]         cmd_time
);

  logic [7:0]  audio_mask;
  logic [3:0]  cont [tspes_pkg::MAX_SOURCES];
  logic [7:0]  pos, pos_next;
  logic [23:0] bytes_left, bytes_left_next;
  logic [2:0]  active_source, active_source_next;
  logic [23:0] pend, pend_next;
  logic [1:0]  pend_cnt, pend_cnt_next;
  logic        tail_flag, tail_flag_next;

  logic        idle;
  logic [2:0]  src_sel;
  logic [3:0]  cc_inc;
  logic        cc_we;
  logic [24:0] size_plus;
  logic [15:0] pes_len;
  logic        at_start;
  logic [7:0]  p0;
  logic [1:0]  cnt0;
  logic [7:0]  wstart;
  logic [5:0]  word_idx;
  logic        last_byte;

  // Shared lookups for the byte being placed.
  assign idle      = (bytes_left == 24'd0);
  assign src_sel   = idle ? item.source : active_source;
  assign cc_inc    = cont[src_sel] + 4'd1;
  assign size_plus = {1'b0, item.unit_size} + tspes_pkg::PES_LEN_EXTRA;
  assign pes_len   = (size_plus[24:16] != 9'd0) ? 16'd0 : size_plus[15:0];
  assign at_start  = (pos == 8'd0);
  assign p0        = at_start ? tspes_pkg::TS_HDR_BYTES : pos;
  assign cnt0      = at_start ? 2'd0 : pend_cnt;
  assign wstart    = p0 - {6'd0, cnt0};
  assign word_idx  = wstart[7:2];
  assign last_byte = (bytes_left == 24'd1);
  assign cmd_time  = item.time_us;

  // Classify the item and work out the packet state it leaves behind.
  always_comb begin
    cmd                = '0;
    cmd_valid          = 1'b0;
    cc_we              = 1'b0;
    pos_next           = pos;
    bytes_left_next    = bytes_left;
    active_source_next = active_source;
    pend_next          = pend;
    pend_cnt_next      = pend_cnt;
    tail_flag_next     = tail_flag;
    cmd.src            = src_sel;
    cmd.cc             = cc_inc;
    cmd.sid            = audio_mask[src_sel] ? tspes_pkg::SID_AUDIO : tspes_pkg::SID_VIDEO;
    cmd.pes_len        = pes_len;
    if (accept && idle && item.unit_start) begin
      // First byte of a unit: full header; units of one byte or none close at once.
      cmd.hdr            = tspes_pkg::HDR_FIRST;
      cmd_valid          = 1'b1;
      cc_we              = 1'b1;
      active_source_next = item.source;
      if (item.unit_size <= 24'd1) begin
        cmd.has_word    = 1'b1;
        cmd.use_tail    = 1'b1;
        cmd.data_word   = {16'd0, (item.unit_size == 24'd0) ? 8'd0 : item.data_byte, 8'd0};
        cmd.zeros       = tspes_pkg::FIRST_PAD_WORDS;
        cmd.ends_packet = 1'b1;
        pos_next        = 8'd0;
        bytes_left_next = 24'd0;
        pend_cnt_next   = 2'd0;
        tail_flag_next  = 1'b0;
      end else begin
        pend_next       = {16'd0, item.data_byte};
        pend_cnt_next   = 2'd3;
        tail_flag_next  = 1'b1;
        pos_next        = tspes_pkg::FIRST_PAYLOAD_POS;
        bytes_left_next = item.unit_size - 24'd1;
      end
    end else if (accept && !idle) begin
      // Later byte of a unit, behind a short header when a packet opens.
      bytes_left_next = bytes_left - 24'd1;
      if (at_start) begin
        cmd.hdr = tspes_pkg::HDR_SHORT;
        cc_we   = 1'b1;
      end
      if (cnt0 == 2'd3) begin
        cmd.has_word   = 1'b1;
        cmd.use_tail   = tail_flag;
        cmd.data_word  = {pend, item.data_byte};
        tail_flag_next = 1'b0;
        pend_cnt_next  = 2'd0;
        if (last_byte) begin
          cmd.zeros       = tspes_pkg::LAST_WORD_IDX - word_idx;
          cmd.ends_packet = 1'b1;
          pos_next        = 8'd0;
        end else begin
          cmd.ends_packet = (word_idx == tspes_pkg::LAST_WORD_IDX);
          pos_next        = cmd.ends_packet ? 8'd0 : (p0 + 8'd1);
        end
      end else if (last_byte) begin
        cmd.has_word = 1'b1;
        case (cnt0)
          2'd0:    cmd.data_word = {item.data_byte, 24'd0};
          2'd1:    cmd.data_word = {pend[7:0], item.data_byte, 16'd0};
          default: cmd.data_word = {pend[15:0], item.data_byte, 8'd0};
        endcase
        cmd.zeros       = tspes_pkg::LAST_WORD_IDX - word_idx;
        cmd.ends_packet = 1'b1;
        pos_next        = 8'd0;
        pend_cnt_next   = 2'd0;
        tail_flag_next  = 1'b0;
      end else begin
        pend_next     = {pend[15:0], item.data_byte};
        pend_cnt_next = cnt0 + 2'd1;
        pos_next      = p0 + 8'd1;
      end
      cmd_valid = at_start || cmd.has_word;
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      audio_mask    <= 8'd0;
      pos           <= 8'd0;
      bytes_left    <= 24'd0;
      active_source <= 3'd0;
      pend_cnt      <= 2'd0;
      tail_flag     <= 1'b0;
      for (int i = 0; i < tspes_pkg::MAX_SOURCES; i++) begin
        cont[i] <= 4'd0;
      end
    end else begin
      if (cfg_write) begin
        audio_mask <= cfg_data;
      end
      pos           <= pos_next;
      bytes_left    <= bytes_left_next;
      active_source <= active_source_next;
      pend_cnt      <= pend_cnt_next;
      tail_flag     <= tail_flag_next;
      if (cc_we) begin
        cont[src_sel] <= cc_inc;
      end
    end
  end

  // Bytes waiting to complete a word.
  always_ff @(posedge clk) begin
    pend <= pend_next;
  end

endmodule

### src/tspes_pts.sv
`timescale 1ns / 1ps
// Pipelined PTS divider: carries each command while time * 9 / 100 is formed.
module tspes_pts (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  tspes_pkg::cmd_t                    in_cmd,
  input  logic [47:0]                        in_time,
  output logic                               out_valid,
  output tspes_pkg::cmd_t                    out_cmd,
  output logic [tspes_pkg::INFLIGHT_W-1:0]   inflight
);

  localparam int NREG = tspes_pkg::PIPE_REGS;

  logic            v     [NREG];
  logic [55:0]     x_s   [NREG];
  logic [6:0]      r_s   [NREG];
  logic [31:0]     q_s   [NREG];
  tspes_pkg::cmd_t cmd_s [NREG];
  logic [51:0]     nine_t;

  // Eight restoring steps of long division by 100 on one dividend byte.
  function automatic logic [14:0] div_byte(input logic [6:0] r_in, input logic [7:0] bits);
    logic [7:0] r;
    logic [7:0] q;
    r = {1'b0, r_in};
    q = 8'd0;
    for (int i = 7; i >= 0; i--) begin
      r = {r[6:0], bits[i]};
      if (r >= tspes_pkg::PTS_DIVISOR) begin
        r    = r - tspes_pkg::PTS_DIVISOR;
        q[i] = 1'b1;
      end
    end
    return {q, r[6:0]};
  endfunction

  assign nine_t = {1'b0, in_time, 3'b000} + {4'd0, in_time};

  // Load stage: dividend is time * 9, most significant byte first.
  always_ff @(posedge clk) begin
    x_s[0]   <= {4'd0, nine_t};
    r_s[0]   <= 7'd0;
    q_s[0]   <= 32'd0;
    cmd_s[0] <= in_cmd;
  end

  // Division stages, one dividend byte each.
  for (genvar s = 1; s < NREG; s++) begin : g_stage
    logic [14:0] step;
    assign step = div_byte(r_s[s-1], x_s[s-1][55:48]);
    always_ff @(posedge clk) begin
      x_s[s]   <= {x_s[s-1][47:0], 8'd0};
      r_s[s]   <= step[6:0];
      q_s[s]   <= {q_s[s-1][23:0], step[14:7]};
      cmd_s[s] <= cmd_s[s-1];
    end
  end

  // Valid bits of the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NREG; i++) begin
        v[i] <= 1'b0;
      end
    end else begin
      v[0] <= in_valid;
      for (int i = 1; i < NREG; i++) begin
        v[i] <= v[i-1];
      end
    end
  end

  // Count of commands still in the divider.
  always_comb begin
    inflight = '0;
    for (int i = 0; i < NREG; i++) begin
      inflight = inflight + {{(tspes_pkg::INFLIGHT_W-1){1'b0}}, v[i]};
    end
  end

  // Result: low 32 bits of the quotient go into the command.
  always_comb begin
    out_cmd     = cmd_s[NREG-1];
    out_cmd.pts = q_s[NREG-1];
  end
  assign out_valid = v[NREG-1];

endmodule

### src/tspes_queue.sv
`timescale 1ns / 1ps
// Command queue with a registered head entry between the front and back ends.
module tspes_queue (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_valid,
  input  tspes_pkg::cmd_t                 wr_data,
  input  logic                            rd_pop,
  output logic                            rd_valid,
  output tspes_pkg::cmd_t                 rd_data,
  output logic [tspes_pkg::OCC_W-1:0]     occupancy
);

  tspes_pkg::cmd_t              mem [tspes_pkg::QUEUE_DEPTH];
  logic [tspes_pkg::QPTR_W-1:0] wr_ptr;
  logic [tspes_pkg::QPTR_W-1:0] rd_ptr;
  logic [tspes_pkg::OCC_W-1:0]  mem_count;
  logic                         head_valid;
  logic                         head_free;
  logic                         mem_empty;
  logic                         mem_we;
  logic                         mem_rd;
  logic                         bypass;

  // Head refills from memory, or straight from the writer when memory is empty.
  assign head_free = !head_valid || rd_pop;
  assign mem_empty = (mem_count == '0);
  assign mem_rd    = head_free && !mem_empty;
  assign bypass    = head_free && mem_empty && wr_valid;
  assign mem_we    = wr_valid && !bypass;
  assign rd_valid  = head_valid;
  assign occupancy = mem_count + {{(tspes_pkg::OCC_W-1){1'b0}}, head_valid};

  // Storage array.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Registered head entry.
  always_ff @(posedge clk) begin
    if (mem_rd) begin
      rd_data <= mem[rd_ptr];
    end else if (bypass) begin
      rd_data <= wr_data;
    end
  end

  // Pointers and counts.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      mem_count  <= '0;
      head_valid <= 1'b0;
    end else begin
      if (mem_we) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (mem_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      mem_count <= mem_count + {{(tspes_pkg::OCC_W-1){1'b0}}, mem_we}
                             - {{(tspes_pkg::OCC_W-1){1'b0}}, mem_rd};
      if (head_free) begin
        head_valid <= mem_rd || bypass;
      end
    end
  end

endmodule

### src/tspes_back.sv
`timescale 1ns / 1ps
// Back end: expands each command into header, data and pad words, one per cycle while the reader pops.
module tspes_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  tspes_pkg::cmd_t     q_data,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output tspes_pkg::result_t  result
);

  tspes_pkg::cmd_t cur;
  logic            cur_valid;
  logic [5:0]      idx;
  logic [5:0]      last_idx;
  logic [2:0]      hdr_n;
  logic [15:0]     tail;
  logic            res_valid;

  logic            advance;
  logic            is_last;
  logic            emit;
  logic            load;
  logic [2:0]      q_hdr_n;
  logic [31:0]     word_now;
  logic [12:0]     pid;
  logic [7:0]      pid_hi;

  // Header words of the current command.
  assign pid    = tspes_pkg::PID_BASE + {10'd0, cur.src};
  assign pid_hi = ((cur.hdr == tspes_pkg::HDR_FIRST) ? tspes_pkg::PUSI_FLAG : 8'd0)
                | {3'd0, pid[12:8]};

  always_comb begin
    word_now = 32'd0;
    if ({3'd0, hdr_n} > idx) begin
      case (idx[1:0])
        2'd0: word_now = {tspes_pkg::SYNC_BYTE, pid_hi, pid[7:0], tspes_pkg::PAYLOAD_ONLY, cur.cc};
        2'd1: word_now = {tspes_pkg::PES_START, cur.sid};
        2'd2: word_now = {cur.pes_len, tspes_pkg::PES_FLAGS0, tspes_pkg::PES_FLAGS1};
        default: word_now = {tspes_pkg::PES_HDR_LEN,
                             tspes_pkg::PTS_PREFIX | {5'd0, cur.pts[31:30], 1'b0},
                             cur.pts[29:22], cur.pts[21:15], 1'b1};
      endcase
    end else if (cur.has_word && idx == {3'd0, hdr_n}) begin
      word_now = cur.use_tail ? {tail, cur.data_word[15:0]} : cur.data_word;
    end
  end

  // Handshake between the command register and the output register.
  assign advance = !res_valid || pop;
  assign is_last = (idx == last_idx);
  assign emit    = advance && cur_valid;
  assign load    = q_valid && (!cur_valid || (emit && is_last));
  assign q_pop   = load;
  assign empty   = !res_valid;

  always_comb begin
    case (q_data.hdr)
      tspes_pkg::HDR_FIRST: q_hdr_n = 3'd4;
      tspes_pkg::HDR_SHORT: q_hdr_n = 3'd1;
      default:              q_hdr_n = 3'd0;
    endcase
  end

  // Command payload, the last two PTS bytes of the open unit and the output word.
  always_ff @(posedge clk) begin
    if (load) begin
      cur      <= q_data;
      hdr_n    <= q_hdr_n;
      last_idx <= {3'd0, q_hdr_n} + {5'd0, q_data.has_word} + q_data.zeros - 6'd1;
      if (q_data.hdr == tspes_pkg::HDR_FIRST) begin
        tail <= {q_data.pts[14:7], q_data.pts[6:0], 1'b1};
      end
    end
    if (emit) begin
      result.word       <= word_now;
      result.packet_end <= is_last && cur.ends_packet;
      result.run_last   <= is_last;
    end
  end

  // Sequencing control.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 6'd0;
      res_valid <= 1'b0;
    end else begin
      if (load) begin
        cur_valid <= 1'b1;
        idx       <= 6'd0;
      end else if (emit) begin
        cur_valid <= !is_last;
        idx       <= idx + 6'd1;
      end
      if (advance) begin
        res_valid <= cur_valid;
      end
    end
  end

endmodule

### src/ts_pes_packetizer_top.sv
`timescale 1ns / 1ps
// Top level of the transport stream PES packetizer.
//
// Takes access-unit payload one byte per item and gives out 188-byte transport
// packets as big-endian 32-bit words, one word per cycle while the reader pops.
// Input items are taken every cycle while full is low; full rises only when the
// 17-entry command queue plus the 8-stage PTS divider pipeline hold as much work
// as the queue can take. On the way to the result ports a byte's first word
// passes the load stage, seven divider stages of one dividend byte each, the
// queue head, the command register and the output register. The first byte of
// a unit expands into four header words, and a unit's last byte into the rest
// of the packet as zero pad words (up to 45 words), so sustained input rate is
// set by the one-word-per-cycle output side.
// The audio source mask is written through cfg_valid/cfg_data; cfg_ready is
// always high and the mask should only change while the block is idle.
module ts_pes_packetizer_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  tspes_pkg::item_t    item,
  output logic                empty,
  input  logic                pop,
  output tspes_pkg::result_t  result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  logic                              accept;
  logic                              f_valid;
  tspes_pkg::cmd_t                   f_cmd;
  logic [47:0]                       f_time;
  logic                              p_valid;
  tspes_pkg::cmd_t                   p_cmd;
  logic [tspes_pkg::INFLIGHT_W-1:0]  inflight;
  logic                              q_valid;
  tspes_pkg::cmd_t                   q_data;
  logic                              q_pop;
  logic [tspes_pkg::OCC_W-1:0]       occupancy;
  logic [tspes_pkg::OCC_W:0]         committed;

  // Every command in flight already has a queue entry reserved.
  assign committed = {1'b0, occupancy} + {{(tspes_pkg::OCC_W+1-tspes_pkg::INFLIGHT_W){1'b0}},
                                          inflight};
  assign full      = (committed >= (tspes_pkg::OCC_W+1)'(tspes_pkg::QUEUE_CAP));
  assign accept    = push && !full;
  assign cfg_ready = 1'b1;

  tspes_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd_valid (f_valid),
    .cmd       (f_cmd),
    .cmd_time  (f_time)
  );

  tspes_pts u_pts (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_cmd    (f_cmd),
    .in_time   (f_time),
    .out_valid (p_valid),
    .out_cmd   (p_cmd),
    .inflight  (inflight)
  );

  tspes_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_valid  (p_valid),
    .wr_data   (p_cmd),
    .rd_pop    (q_pop),
    .rd_valid  (q_valid),
    .rd_data   (q_data),
    .occupancy (occupancy)
  );

  tspes_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  // Reserved queue space is never exceeded.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    committed <= (tspes_pkg::OCC_W+1)'(tspes_pkg::QUEUE_CAP))
    else $error("command queue over-committed");

  // The back end takes a command only when the queue head holds one.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("command taken from an empty queue");

  // A packet always closes on the last word of its command.
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.packet_end) |-> result.run_last)
    else $error("packet end inside a word run");

endmodule
